[design/dll_pkg.sv]
// Package for the doubly linked list engine: widths, command and status codes.
// No dependencies.
package dll_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CMD_W = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int ST_W = 3;

    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READOUT  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] element;
        logic                    last;
    } res_t;
endpackage

[design/dll_if.sv]
// Valid/ready channel interfaces: one carries a cmd_t payload, the other a res_t payload.
// Depends on dll_pkg for payload types.
interface dll_cmd_if import dll_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dll_res_if import dll_pkg::*; ();
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/doubly_linked_list_engine.sv]
// Doubly linked list engine: a pool of CAPACITY nodes kept in three small RAMs.
// Head and tail inserts go straight from S_IDLE to S_LINK; position insert past
// position 1 and delete walk the list node by node through S_WAIT and S_WALK
// (registered RAM read on the walk), and readout returns one element per node,
// up to the smaller of MAX_RESULTS and CAPACITY. A two-entry command queue decouples the input.
// Depends on dll_pkg, dll_if, dll_front, dll_back and dll_ram.
module doubly_linked_list_engine import dll_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    dll_cmd_if.sink    cmd_in,
    dll_res_if.source  res_out
);
    logic q_valid, q_pop;
    cmd_t q_data;

    dll_front u_front (.clk, .rst_n, .cmd_in, .q_valid, .q_data, .q_pop);
    dll_back #(.CAPACITY(CAPACITY)) u_back (
        .clk, .rst_n, .q_valid, .q_data, .q_pop, .res_out);

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |=> res_out.valid)
        else $error("result dropped");
endmodule

[design/dll_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/dll_front.sv]
// Front end: accepts commands, drops undefined codes, keeps a two-entry queue.
// Depends on dll_pkg and dll_if.
module dll_front import dll_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    dll_cmd_if.sink  cmd_in,
    output logic     q_valid,
    output cmd_t     q_data,
    input  logic     q_pop
);
    cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic rd_reg, rd_next;
    logic push, legal;

    assign legal = cmd_in.data.cmd <= CMD_READOUT;
    assign cmd_in.ready = cnt_reg != 2'd2;
    assign push = cmd_in.valid && cmd_in.ready && legal;
    assign q_valid = cnt_reg != 2'd0;
    assign q_data = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
        rd_next = rd_reg ^ q_pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[rd_reg ^ cnt_reg[0]] <= cmd_in.data;
        end
    end
endmodule

[design/dll_back.sv]
// Back end: walks and edits the node pool, reading one node at a time.
// Depends on dll_pkg, dll_if and dll_ram.
module dll_back import dll_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  cmd_t     q_data,
    output logic     q_pop,
    dll_res_if.source res_out
);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);
    localparam int LIM = (MAX_RESULTS < CAPACITY) ? MAX_RESULTS : CAPACITY;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [CAPACITY-1:0] free_reg, free_next;
    logic [IW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [IW-1:0] count_reg, count_next;
    cmd_t cur_reg, cur_next;
    logic [IW-1:0] node_reg, node_next;
    logic [POS_W-1:0] steps_reg, steps_next;
    logic [IW:0] k_reg, k_next;
    logic rv_reg, rv_next;
    res_t res_reg, res_next;
    logic [IW-1:0] slot;
    logic [IW-1:0] nx_reg, nx_next;

    logic v_we, n_we, p_we, n_we2;
    logic [AW-1:0] v_wa, n_wa, p_wa, raddr;
    logic [VAL_W-1:0] v_wd, v_rd;
    logic [IW-1:0] n_wd, p_wd, n_rd, p_rd;
    logic [AW-1:0] n_wa2;
    logic [IW-1:0] n_wd2;
    logic n_we_m, p_we_m;
    logic [AW-1:0] n_wa_m, p_wa_m;
    logic [IW-1:0] n_wd_m, p_wd_m;

    dll_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val (
        .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(raddr), .rdata(v_rd));
    dll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
        .clk, .we(n_we_m), .waddr(n_wa_m), .wdata(n_wd_m), .raddr(raddr), .rdata(n_rd));
    dll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
        .clk, .we(p_we_m), .waddr(p_wa_m), .wdata(p_wd_m), .raddr(raddr), .rdata(p_rd));

    always_comb
    begin
        slot = NIL;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                slot = IW'(i);
            end
        end
    end

    assign res_out.valid = rv_reg;
    assign res_out.data = res_reg;
    assign raddr = node_next[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        free_next = free_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        cur_next = cur_reg;
        node_next = node_reg;
        steps_next = steps_reg;
        k_next = k_reg;
        nx_next = nx_reg;
        rv_next = rv_reg && !res_out.ready;
        res_next = res_reg;
        q_pop = 1'b0;
        v_we = 1'b0; n_we = 1'b0; p_we = 1'b0; n_we2 = 1'b0;
        v_wa = slot[AW-1:0]; v_wd = cur_reg.value;
        n_wa = slot[AW-1:0]; n_wd = NIL;
        p_wa = slot[AW-1:0]; p_wd = NIL;
        n_wa2 = '0; n_wd2 = NIL;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !rv_next)
                begin
                    q_pop = 1'b1;
                    cur_next = q_data;
                    res_next.element = q_data.value;
                    res_next.last = 1'b1;
                    res_next.status = ST_OK;
                    case (q_data.cmd)
                        CMD_INS_HEAD, CMD_INS_TAIL:
                        begin
                            if (slot == NIL)
                            begin
                                res_next.status = ST_FULL;
                                rv_next = 1'b1;
                            end
                            else
                            begin
                                node_next = (q_data.cmd == CMD_INS_HEAD) ? NIL : tail_reg;
                                nx_next = (q_data.cmd == CMD_INS_HEAD) ? head_reg : NIL;
                                state_next = S_LINK;
                            end
                        end
                        CMD_INS_POS:
                        begin
                            if (q_data.position == '0)
                            begin
                                res_next.status = ST_INVALID;
                                rv_next = 1'b1;
                            end
                            else if (count_reg >= NIL)
                            begin
                                res_next.status = ST_FULL;
                                rv_next = 1'b1;
                            end
                            else if ({1'b0, q_data.position} > 9'(count_reg) + 9'd1)
                            begin
                                res_next.status = ST_RANGE;
                                rv_next = 1'b1;
                            end
                            else if (q_data.position == 8'd1)
                            begin
                                node_next = NIL;
                                nx_next = head_reg;
                                state_next = S_LINK;
                            end
                            else
                            begin
                                node_next = head_reg;
                                steps_next = q_data.position - 8'd2;
                                state_next = S_WAIT;
                            end
                        end
                        CMD_DELETE, CMD_READOUT:
                        begin
                            if (head_reg == NIL)
                            begin
                                res_next.status = ST_EMPTY;
                                if (q_data.cmd == CMD_READOUT)
                                begin
                                    res_next.element = '0;
                                end
                                rv_next = 1'b1;
                            end
                            else
                            begin
                                node_next = head_reg;
                                k_next = '0;
                                state_next = S_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WAIT:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                case (cur_reg.cmd)
                    CMD_INS_POS:
                    begin
                        if (steps_reg == '0)
                        begin
                            nx_next = n_rd;
                            state_next = S_LINK;
                        end
                        else
                        begin
                            steps_next = steps_reg - 8'd1;
                            node_next = n_rd;
                            state_next = S_WAIT;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (v_rd == cur_reg.value)
                        begin
                            if (p_rd == NIL) head_next = n_rd;
                            else
                            begin
                                n_we = 1'b1; n_wa = p_rd[AW-1:0]; n_wd = n_rd;
                            end
                            if (n_rd == NIL) tail_next = p_rd;
                            else
                            begin
                                p_we = 1'b1; p_wa = n_rd[AW-1:0]; p_wd = p_rd;
                            end
                            free_next[node_reg[AW-1:0]] = 1'b1;
                            count_next = count_reg - IW'(1);
                            res_next.status = ST_OK;
                            rv_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (n_rd == NIL)
                        begin
                            res_next.status = ST_NOTFOUND;
                            rv_next = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            node_next = n_rd;
                            state_next = S_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                if (!rv_next)
                begin
                    res_next.status = ST_OK;
                    res_next.element = v_rd;
                    res_next.last = (n_rd == NIL) || (k_reg == (IW+1)'(LIM - 1));
                    rv_next = 1'b1;
                    k_next = k_reg + (IW+1)'(1);
                    node_next = n_rd;
                    state_next = res_next.last ? S_IDLE : S_WAIT;
                end
            end
            S_LINK:
            begin
                v_we = 1'b1;
                n_we = 1'b1; n_wd = nx_reg;
                p_we = 1'b1; p_wd = node_reg;
                if (node_reg == NIL) head_next = slot;
                else
                begin
                    n_we2 = 1'b1; n_wa2 = node_reg[AW-1:0]; n_wd2 = slot;
                end
                if (nx_reg == NIL) tail_next = slot;
                free_next[slot[AW-1:0]] = 1'b0;
                count_next = count_reg + IW'(1);
                res_next.status = ST_OK;
                rv_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Second write to the same pools is done in the cycle after linking.
    logic pend_reg;
    logic [AW-1:0] pend_a_reg;
    logic [IW-1:0] pend_d_reg;
    logic pv_pend_reg;
    logic [AW-1:0] pv_a_reg;
    logic [IW-1:0] pv_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            free_reg <= '1;
            head_reg <= NIL;
            tail_reg <= NIL;
            count_reg <= '0;
            rv_reg <= 1'b0;
            pend_reg <= 1'b0;
            pv_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg <= free_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
            rv_reg <= rv_next;
            pend_reg <= n_we2;
            pv_pend_reg <= (state_reg == S_LINK) && (nx_reg != NIL);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        node_reg <= node_next;
        steps_reg <= steps_next;
        k_reg <= k_next;
        nx_reg <= nx_next;
        res_reg <= res_next;
        pend_a_reg <= n_wa2;
        pend_d_reg <= n_wd2;
        pv_a_reg <= nx_reg[AW-1:0];
        pv_d_reg <= slot;
    end

    // Deferred link fixups are merged into the next and prev RAM write ports.
    logic fix_n_we, fix_p_we;
    assign fix_n_we = pend_reg;
    assign fix_p_we = pv_pend_reg;

    // Merge: deferred writes take priority over the main path and land in S_IDLE,
    // which always follows S_LINK and writes no RAM, so there is no clash.
    always_comb
    begin
        if (fix_n_we)
        begin
            n_we_m = 1'b1; n_wa_m = pend_a_reg; n_wd_m = pend_d_reg;
        end
        else
        begin
            n_we_m = n_we; n_wa_m = n_wa; n_wd_m = n_wd;
        end
        if (fix_p_we)
        begin
            p_we_m = 1'b1; p_wa_m = pv_a_reg; p_wd_m = pv_d_reg;
        end
        else
        begin
            p_we_m = p_we; p_wa_m = p_wa; p_wd_m = p_wd;
        end
    end
endmodule

[tb/tb_doubly_linked_list_engine.sv]
// Testbench for doubly_linked_list_engine: directed table then random command mix,
// every result checked against a behavioral list model. Depends on dll_pkg, dll_if
// and the engine RTL.
`timescale 1ns / 1ps
module tb_doubly_linked_list_engine;
    import dll_pkg::*;

    localparam int CAP = 16;
    localparam int NUM_RANDOM = 235;
    localparam logic [CMD_W-1:0] CMD_NOISE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NOISE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dll_cmd_if cmd_ch ();
    dll_res_if res_ch ();

    doubly_linked_list_engine #(.CAPACITY(CAP)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_in(cmd_ch.sink),
        .res_out(res_ch.source)
    );

    always #2 clk = ~clk;

    // list contents kept as a plain ordered array
    logic signed [VAL_W-1:0] list_vals[$];
    res_t pending_res[$];
    int errors = 0;
    int res_seen = 0;
    int cmds_sent = 0;
    logic stim_done = 1'b0;

    function automatic res_t mk_res(logic [ST_W-1:0] s, logic signed [VAL_W-1:0] e,
                                    logic l);
        res_t r;
        r.status = s;
        r.element = e;
        r.last = l;
        return r;
    endfunction

    task automatic apply_list_cmd(cmd_t c);
        int idx;
        case (c.cmd)
            CMD_INS_HEAD, CMD_INS_TAIL:
            begin
                if (list_vals.size() >= CAP)
                    pending_res.push_back(mk_res(ST_FULL, c.value, 1'b1));
                else
                begin
                    if (c.cmd == CMD_INS_HEAD)
                        list_vals.push_front(c.value);
                    else
                        list_vals.push_back(c.value);
                    pending_res.push_back(mk_res(ST_OK, c.value, 1'b1));
                end
            end
            CMD_INS_POS:
            begin
                if (c.position == 0)
                    pending_res.push_back(mk_res(ST_INVALID, c.value, 1'b1));
                else if (list_vals.size() >= CAP)
                    pending_res.push_back(mk_res(ST_FULL, c.value, 1'b1));
                else if (int'(c.position) > list_vals.size() + 1)
                    pending_res.push_back(mk_res(ST_RANGE, c.value, 1'b1));
                else
                begin
                    list_vals.insert(int'(c.position) - 1, c.value);
                    pending_res.push_back(mk_res(ST_OK, c.value, 1'b1));
                end
            end
            CMD_DELETE:
            begin
                if (list_vals.size() == 0)
                    pending_res.push_back(mk_res(ST_EMPTY, c.value, 1'b1));
                else
                begin
                    idx = -1;
                    for (int i = 0; i < list_vals.size(); i++)
                        if (idx < 0 && list_vals[i] == c.value)
                            idx = i;
                    if (idx < 0)
                        pending_res.push_back(mk_res(ST_NOTFOUND, c.value, 1'b1));
                    else
                    begin
                        list_vals.delete(idx);
                        pending_res.push_back(mk_res(ST_OK, c.value, 1'b1));
                    end
                end
            end
            CMD_READOUT:
            begin
                if (list_vals.size() == 0)
                    pending_res.push_back(mk_res(ST_EMPTY, '0, 1'b1));
                else
                    for (int i = 0; i < list_vals.size() && i < MAX_RESULTS; i++)
                        pending_res.push_back(mk_res(ST_OK, list_vals[i],
                            i == list_vals.size() - 1 || i == MAX_RESULTS - 1));
            end
            default:
            begin
            end
        endcase
    endtask

    // directed table: cmd, value, position, typed status (typed clear for predictor only)
    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
        bit                      typed;
        logic [ST_W-1:0]         status;
    } row_t;

    row_t dir_rows[$];

    task automatic add_row(logic [CMD_W-1:0] c, logic signed [VAL_W-1:0] v,
                           logic [POS_W-1:0] p, bit t, logic [ST_W-1:0] s);
        row_t r;
        r.cmd = c;
        r.value = v;
        r.position = p;
        r.typed = t;
        r.status = s;
        dir_rows.push_back(r);
    endtask

    task automatic send_cmd(cmd_t c);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        apply_list_cmd(c);
        cmds_sent++;
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (2 * CAP + 10) @(posedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return $signed(VAL_W'($urandom_range(0, 7)));
        if (k == 6)
            return 32'sh7fff_ffff;
        if (k == 7)
            return 32'sh8000_0000;
        return $signed($urandom());
    endfunction

    function automatic logic [CMD_W-1:0] pick_noise_cmd();
        return CMD_W'($urandom_range(CMD_NOISE_LO, CMD_NOISE_HI));
    endfunction

    initial
    begin
        cmd_t c;
        int mode;
        int k;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(CMD_READOUT, 32'sd0, 8'd0, 1'b1, ST_EMPTY);
        add_row(CMD_DELETE, 32'sd5, 8'd0, 1'b1, ST_EMPTY);
        add_row(CMD_INS_POS, 32'sd9, 8'd0, 1'b1, ST_INVALID);
        add_row(CMD_INS_POS, 32'sd9, 8'd2, 1'b1, ST_RANGE);
        add_row(CMD_INS_POS, 32'sh7fff_ffff, 8'd1, 1'b1, ST_OK);
        add_row(CMD_INS_HEAD, 32'sh8000_0000, 8'd0, 1'b1, ST_OK);
        add_row(CMD_INS_TAIL, -32'sd1, 8'hff, 1'b1, ST_OK);
        add_row(CMD_INS_POS, 32'sd3, 8'd4, 1'b0, ST_OK);
        add_row(CMD_INS_POS, 32'sd4, 8'd3, 1'b0, ST_OK);
        add_row(CMD_INS_POS, 32'sd4, 8'd255, 1'b1, ST_RANGE);
        add_row(CMD_READOUT, 32'sd0, 8'd0, 1'b0, ST_OK);
        add_row(CMD_DELETE, 32'sd77, 8'd0, 1'b1, ST_NOTFOUND);
        add_row(CMD_DELETE, 32'sh8000_0000, 8'd0, 1'b0, ST_OK);
        add_row(CMD_DELETE, 32'sd3, 8'd0, 1'b0, ST_OK);
        add_row(CMD_DELETE, -32'sd1, 8'd0, 1'b0, ST_OK);
        add_row(CMD_NOISE_LO, 32'sd1, 8'd1, 1'b0, ST_OK);
        add_row(CMD_NOISE_HI, 32'sd1, 8'd1, 1'b0, ST_OK);
        for (int i = 0; i < 15; i++)
            add_row(CMD_INS_TAIL, 32'(i), 8'd0, 1'b0, ST_OK);
        add_row(CMD_INS_HEAD, 32'sd50, 8'd0, 1'b1, ST_FULL);
        add_row(CMD_INS_POS, 32'sd51, 8'd0, 1'b1, ST_INVALID);
        add_row(CMD_INS_POS, 32'sd51, 8'd200, 1'b1, ST_FULL);
        add_row(CMD_READOUT, 32'sd0, 8'd0, 1'b0, ST_OK);

        foreach (dir_rows[i])
        begin
            c.cmd = dir_rows[i].cmd;
            c.value = dir_rows[i].value;
            c.position = dir_rows[i].position;
            send_cmd(c);
            if (dir_rows[i].typed && pending_res.size() != 0
                && pending_res[$].status != dir_rows[i].status)
            begin
                $display("%0t directed row %0d: expected status %0d, model gives %0d",
                         $time, i, dir_rows[i].status, pending_res[$].status);
                errors++;
            end
        end
        drain_results();

        // random phases biased toward fill or drain
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            mode = (i / 40) % 2;
            k = $urandom_range(0, 99);
            if (k < 3)
                c.cmd = pick_noise_cmd();
            else if (k < 15)
                c.cmd = CMD_READOUT;
            else if (k < (mode ? 70 : 35))
                c.cmd = CMD_DELETE;
            else if (k < (mode ? 78 : 55))
                c.cmd = CMD_INS_HEAD;
            else if (k < (mode ? 86 : 75))
                c.cmd = CMD_INS_TAIL;
            else
                c.cmd = CMD_INS_POS;
            c.value = pick_value();
            if (c.cmd == CMD_DELETE && list_vals.size() != 0 && $urandom_range(0, 3) != 0)
                c.value = list_vals[$urandom_range(0, list_vals.size() - 1)];
            k = $urandom_range(0, 9);
            if (k == 0)
                c.position = 8'($urandom());
            else if (k == 1)
                c.position = '0;
            else
                c.position = 8'($urandom_range(1, list_vals.size() + 2));
            send_cmd(c);
        end
        cmd_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // result sink with random stalls
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        res_t exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            res_seen++;
            if (pending_res.size() == 0)
            begin
                $display("%0t unexpected transfer: status %0d element %0d last %0b",
                         $time, res_ch.data.status, res_ch.data.element, res_ch.data.last);
                errors++;
            end
            else
            begin
                exp_r = pending_res.pop_front();
                if (res_ch.data.status !== exp_r.status)
                begin
                    $display("%0t status: expected %0d actual %0d",
                             $time, exp_r.status, res_ch.data.status);
                    errors++;
                end
                if (res_ch.data.element !== exp_r.element)
                begin
                    $display("%0t element: expected %0d actual %0d",
                             $time, exp_r.element, res_ch.data.element);
                    errors++;
                end
                if (res_ch.data.last !== exp_r.last)
                begin
                    $display("%0t last: expected %0b actual %0b",
                             $time, exp_r.last, res_ch.data.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (2 * CAP + 20) @(posedge clk);
        $display("Sent %0d commands, checked %0d result transfers.", cmds_sent, res_seen);
        if (errors == 0 && pending_res.size() == 0)
            $display("doubly_linked_list_engine regression: pass");
        else
            $display("doubly_linked_list_engine regression: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timed out with %0d results outstanding.", pending_res.size());
        $display("doubly_linked_list_engine regression: fail");
        $finish;
    end
endmodule
